// ===== rtl/cbrs_pkg.sv =====
// Shared widths, constants and controller/datapath interface types for the span converter.
package cbrs_pkg;

  // Widths of the item fields.
  localparam int unsigned COL_W   = 10;
  localparam int unsigned BOUND_W = 16;
  // Bounds are held one bit wider so that a bound plus one never wraps.
  localparam int unsigned EXT_W   = BOUND_W + 1;

  // Default depth of the start-column store.
  localparam int unsigned MAX_ROWS_DEF = 64;
  // Column wrap; the column field spans exactly this many values.
  localparam int unsigned MAX_COLUMNS  = 1 << COL_W;

  // The four passes over the bounds of one column.
  typedef enum logic [1:0] {
    PH_CLOSE_TOP = 2'd0,
    PH_CLOSE_BOT = 2'd1,
    PH_OPEN_TOP  = 2'd2,
    PH_OPEN_BOT  = 2'd3
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;       // capture a new item
    logic   setup;      // evaluate the row range of one pass
    phase_e phase;      // pass that setup evaluates
    logic   r_from_lo0; // row counter takes the low end of the upward range
    logic   r_from_hi1; // row counter takes the high end of the downward range
    logic   step_up;
    logic   step_down;
    logic   mem_rd;
    logic   mem_wr;
    logic   out_load;
    logic   out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ne0;      // upward range holds at least one stored row
    logic ne1;      // downward range holds at least one stored row
    logic r_at_hi0; // row counter at the end of the upward range
    logic r_at_lo1; // row counter at the end of the downward range
    logic out_free; // output register can take a result this cycle
  } sts_t;

endpackage

// ===== rtl/cbrs_dpath.sv =====
// Datapath of the span converter: bounds, range evaluation, row counter, store, output register.
module cbrs_dpath import cbrs_pkg::*; #(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  logic [COL_W-1:0]            column_i,
  input  logic [BOUND_W-1:0]          prev_top_i,
  input  logic [BOUND_W-1:0]          prev_bottom_i,
  input  logic [BOUND_W-1:0]          cur_top_i,
  input  logic [BOUND_W-1:0]          cur_bottom_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [$clog2(MAX_ROWS)-1:0] span_row_o,
  output logic [COL_W-1:0]            span_first_col_o,
  output logic [COL_W-1:0]            span_last_col_o,
  output logic                        last_of_run_o
);

  localparam int unsigned ROW_W = $clog2(MAX_ROWS);
  localparam logic [EXT_W-1:0] ROW_MAX = EXT_W'(MAX_ROWS - 1);
  localparam logic [EXT_W-1:0] ONE     = EXT_W'(1);

  logic [EXT_W-1:0] t1_q, b1_q, t2_q, b2_q;
  logic [COL_W-1:0] col_q;

  logic [ROW_W-1:0] lo0_q, hi0_q, lo1_q, hi1_q;
  logic             ne0_q, ne1_q;
  logic [ROW_W-1:0] r_q;

  logic [COL_W-1:0] mem_q [MAX_ROWS];
  logic [COL_W-1:0] rd_data_q;

  logic             out_valid_q;
  logic [ROW_W-1:0] span_row_q;
  logic [COL_W-1:0] span_first_q, span_last_q;
  logic             last_q;

  logic             cond;
  logic [EXT_W-1:0] e_v, lo_v, hi_v, bnd_v, hi_c;
  logic             ne_c;
  logic [COL_W:0]   lc_sum;
  logic [COL_W-1:0] last_col;
  logic             out_free;

  // Row range of one pass; bnd_v is the bound left for the passes that follow.
  always_comb begin
    cond  = 1'b0;
    e_v   = t1_q;
    lo_v  = t1_q;
    hi_v  = t1_q;
    bnd_v = t1_q;
    case (cmd_i.phase)
      PH_CLOSE_TOP: begin
        cond  = (t1_q < t2_q) && (t1_q <= b1_q);
        e_v   = ((t2_q - ONE) < b1_q) ? (t2_q - ONE) : b1_q;
        lo_v  = t1_q;
        hi_v  = e_v;
        bnd_v = cond ? (e_v + ONE) : t1_q;
      end
      PH_CLOSE_BOT: begin
        cond  = (b1_q > b2_q) && (b1_q >= t1_q);
        e_v   = ((b2_q + ONE) > t1_q) ? (b2_q + ONE) : t1_q;
        lo_v  = e_v;
        hi_v  = b1_q;
        bnd_v = cond ? (e_v - ONE) : b1_q;
      end
      PH_OPEN_TOP: begin
        cond  = (t2_q < t1_q) && (t2_q <= b2_q);
        e_v   = ((t1_q - ONE) < b2_q) ? (t1_q - ONE) : b2_q;
        lo_v  = t2_q;
        hi_v  = e_v;
        bnd_v = cond ? (e_v + ONE) : t2_q;
      end
      PH_OPEN_BOT: begin
        cond  = (b2_q > b1_q) && (b2_q >= t2_q);
        e_v   = ((b1_q + ONE) > t2_q) ? (b1_q + ONE) : t2_q;
        lo_v  = e_v;
        hi_v  = b2_q;
        bnd_v = t2_q;
      end
      default: begin
        cond = 1'b0;
      end
    endcase
    hi_c = (hi_v < ROW_MAX) ? hi_v : ROW_MAX;
    // Rows beyond the store are cut from the range and never touched.
    ne_c = cond && (lo_v <= ROW_MAX);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= column_i;
      t1_q  <= {1'b0, prev_top_i};
      b1_q  <= {1'b0, prev_bottom_i};
      t2_q  <= {1'b0, cur_top_i};
      b2_q  <= {1'b0, cur_bottom_i};
    end else if (cmd_i.setup) begin
      case (cmd_i.phase)
        PH_CLOSE_TOP: t1_q <= bnd_v;
        PH_CLOSE_BOT: b1_q <= bnd_v;
        PH_OPEN_TOP:  t2_q <= bnd_v;
        default:      t2_q <= t2_q;
      endcase
    end
  end

  // Slot 0 holds the upward range (top passes), slot 1 the downward range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne0_q <= 1'b0;
      ne1_q <= 1'b0;
    end else if (cmd_i.setup) begin
      if (cmd_i.phase == PH_CLOSE_TOP || cmd_i.phase == PH_OPEN_TOP) begin
        ne0_q <= ne_c;
      end else begin
        ne1_q <= ne_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      if (cmd_i.phase == PH_CLOSE_TOP || cmd_i.phase == PH_OPEN_TOP) begin
        lo0_q <= lo_v[ROW_W-1:0];
        hi0_q <= hi_c[ROW_W-1:0];
      end else begin
        lo1_q <= lo_v[ROW_W-1:0];
        hi1_q <= hi_c[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.r_from_lo0) begin
      r_q <= lo0_q;
    end else if (cmd_i.r_from_hi1) begin
      r_q <= hi1_q;
    end else if (cmd_i.step_up) begin
      r_q <= r_q + ROW_W'(1);
    end else if (cmd_i.step_down) begin
      r_q <= r_q - ROW_W'(1);
    end
  end

  // Start-column store: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[r_q] <= col_q;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem_q[r_q];
    end
  end

  // Previous column, wrapping at the column count (a power of two).
  assign lc_sum   = {1'b0, col_q} + (COL_W + 1)'(MAX_COLUMNS - 1);
  assign last_col = lc_sum[COL_W-1:0];

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      span_row_q   <= r_q;
      span_first_q <= rd_data_q;
      span_last_q  <= last_col;
      last_q       <= cmd_i.out_last;
    end
  end

  assign sts_o.ne0      = ne0_q;
  assign sts_o.ne1      = ne1_q;
  assign sts_o.r_at_hi0 = (r_q == hi0_q);
  assign sts_o.r_at_lo1 = (r_q == lo1_q);
  assign sts_o.out_free = out_free;

  assign out_valid_o      = out_valid_q;
  assign span_row_o       = span_row_q;
  assign span_first_col_o = span_first_q;
  assign span_last_col_o  = span_last_q;
  assign last_of_run_o    = last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_up_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_up |-> (r_q < hi0_q))
    else $error("row counter steps past the end of the upward range");

  a_down_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_down |-> (r_q > lo1_q))
    else $error("row counter steps past the end of the downward range");

  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.mem_wr && cmd_i.mem_rd))
    else $error("store read and written in the same cycle");

endmodule

// ===== rtl/cbrs_ctrl.sv =====
// Controller of the span converter: sequences the passes of one item over the datapath.
module cbrs_ctrl import cbrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SET_A    = 4'd1;
  localparam logic [3:0] S_SET_B    = 4'd2;
  localparam logic [3:0] S_PICK_CL  = 4'd3;
  localparam logic [3:0] S_RD_A     = 4'd4;
  localparam logic [3:0] S_EM_A     = 4'd5;
  localparam logic [3:0] S_RD_B     = 4'd6;
  localparam logic [3:0] S_EM_B     = 4'd7;
  localparam logic [3:0] S_SET_C    = 4'd8;
  localparam logic [3:0] S_SET_D    = 4'd9;
  localparam logic [3:0] S_PICK_OP  = 4'd10;
  localparam logic [3:0] S_WR_C     = 4'd11;
  localparam logic [3:0] S_WR_D     = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SET_A;
        end
      end
      S_SET_A: begin
        cmd_o.setup = 1'b1;
        cmd_o.phase = PH_CLOSE_TOP;
        state_d     = S_SET_B;
      end
      S_SET_B: begin
        cmd_o.setup = 1'b1;
        cmd_o.phase = PH_CLOSE_BOT;
        state_d     = S_PICK_CL;
      end
      S_PICK_CL: begin
        if (sts_i.ne0) begin
          cmd_o.r_from_lo0 = 1'b1;
          state_d          = S_RD_A;
        end else if (sts_i.ne1) begin
          cmd_o.r_from_hi1 = 1'b1;
          state_d          = S_RD_B;
        end else begin
          state_d = S_SET_C;
        end
      end
      S_RD_A: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_EM_A;
      end
      S_EM_A: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = sts_i.r_at_hi0 && !sts_i.ne1;
          if (!sts_i.r_at_hi0) begin
            cmd_o.step_up = 1'b1;
            state_d       = S_RD_A;
          end else if (sts_i.ne1) begin
            cmd_o.r_from_hi1 = 1'b1;
            state_d          = S_RD_B;
          end else begin
            state_d = S_SET_C;
          end
        end
      end
      S_RD_B: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_EM_B;
      end
      S_EM_B: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = sts_i.r_at_lo1;
          if (sts_i.r_at_lo1) begin
            state_d = S_SET_C;
          end else begin
            cmd_o.step_down = 1'b1;
            state_d         = S_RD_B;
          end
        end
      end
      S_SET_C: begin
        cmd_o.setup = 1'b1;
        cmd_o.phase = PH_OPEN_TOP;
        state_d     = S_SET_D;
      end
      S_SET_D: begin
        cmd_o.setup = 1'b1;
        cmd_o.phase = PH_OPEN_BOT;
        state_d     = S_PICK_OP;
      end
      S_PICK_OP: begin
        if (sts_i.ne0) begin
          cmd_o.r_from_lo0 = 1'b1;
          state_d          = S_WR_C;
        end else if (sts_i.ne1) begin
          cmd_o.r_from_hi1 = 1'b1;
          state_d          = S_WR_D;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WR_C: begin
        cmd_o.mem_wr = 1'b1;
        if (!sts_i.r_at_hi0) begin
          cmd_o.step_up = 1'b1;
        end else if (sts_i.ne1) begin
          cmd_o.r_from_hi1 = 1'b1;
          state_d          = S_WR_D;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WR_D: begin
        cmd_o.mem_wr = 1'b1;
        if (sts_i.r_at_lo1) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.step_down = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/column_bounds_to_row_spans.sv =====
// Top level of the column-to-span converter: controller and datapath joined by commands and status.
// After a column's transfer in, its first span goes through S_SET_A, S_SET_B, S_PICK_CL and a store
// read state, then waits for a free output register. A new item is taken only in S_IDLE, once all
// spans closed by the last item (one start-column store read and one output load each) and all rows
// opened by it (one store write each) are done; the single-port start-column store serialises them.
// Reset clears the controller, the output valid flag and the range flags; the start-column store is not
// cleared and holds no meaning for a row until a column has opened that row.
module column_bounds_to_row_spans import cbrs_pkg::*; #(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [COL_W-1:0]            column_i,
  input  logic [BOUND_W-1:0]          prev_top_i,
  input  logic [BOUND_W-1:0]          prev_bottom_i,
  input  logic [BOUND_W-1:0]          cur_top_i,
  input  logic [BOUND_W-1:0]          cur_bottom_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [$clog2(MAX_ROWS)-1:0] span_row_o,
  output logic [COL_W-1:0]            span_first_col_o,
  output logic [COL_W-1:0]            span_last_col_o,
  output logic                        last_of_run_o
);

  // The controller walks each column through four passes: close rows above the new top,
  // close rows below the new bottom, then open rows newly covered at the top and bottom.
  // The datapath sets up both close ranges before either is walked, and then both open ranges.
  cmd_t cmd;
  sts_t sts;

  cbrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the bounds, the row counter, the start-column store and the output
  // register, so a finished span waits there while the controller carries on with the next.
  cbrs_dpath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .column_i         (column_i),
    .prev_top_i       (prev_top_i),
    .prev_bottom_i    (prev_bottom_i),
    .cur_top_i        (cur_top_i),
    .cur_bottom_i     (cur_bottom_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .span_row_o       (span_row_o),
    .span_first_col_o (span_first_col_o),
    .span_last_col_o  (span_last_col_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

// ===== tb/column_bounds_to_row_spans_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the column-to-span converter, with its own span predictor.
module column_bounds_to_row_spans_test;
  import cbrs_pkg::*;

  localparam int unsigned          ROWS            = MAX_ROWS_DEF;
  localparam int unsigned          ROW_W           = $clog2(ROWS);
  localparam logic [BOUND_W-1:0]   EMPTY_TOP       = '1;
  localparam int unsigned          CLK_PERIOD      = 10;
  localparam int unsigned          RESET_CYCLES    = 12;
  // Long enough for the output side to back up well into the input side.
  localparam int unsigned          HOLD_OFF_CYCLES = 400;
  // Cycles without a single transfer on either side before the run is abandoned.
  localparam int unsigned          STALL_LIMIT     = 5000;
  // Quiet time after the last expected span.
  localparam int unsigned          TAIL_CYCLES     = 50;
  localparam int unsigned          PLANE_ITEMS     = 60;
  localparam int unsigned          NOISE_ITEMS     = 20;
  localparam int unsigned          STEADY_ITEMS    = 30;

  // One column as it is presented to the block.
  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [BOUND_W-1:0] prev_top;
    logic [BOUND_W-1:0] prev_bottom;
    logic [BOUND_W-1:0] cur_top;
    logic [BOUND_W-1:0] cur_bottom;
  } column_item_t;

  // One finished horizontal span.
  typedef struct packed {
    logic [ROW_W-1:0] span_row;
    logic [COL_W-1:0] span_first_col;
    logic [COL_W-1:0] span_last_col;
    logic             last_of_run;
  } span_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [COL_W-1:0]   column;
  logic [BOUND_W-1:0] prev_top;
  logic [BOUND_W-1:0] prev_bottom;
  logic [BOUND_W-1:0] cur_top;
  logic [BOUND_W-1:0] cur_bottom;
  logic               out_valid;
  logic               out_ready;
  logic [ROW_W-1:0]   span_row;
  logic [COL_W-1:0]   span_first_col;
  logic [COL_W-1:0]   span_last_col;
  logic               last_of_run;

  // Predicted spans, oldest first, and the predictor's own copy of the start-column store.
  span_t            pending_spans[$];
  logic [COL_W-1:0] span_start[ROWS];

  // Flags shared between the test tasks, the sending task and the receiver process.
  logic tx_steady    = 1'b0;
  logic rx_steady    = 1'b0;
  logic hold_off_req = 1'b0;

  int unsigned errors        = 0;
  int unsigned columns_sent  = 0;
  int unsigned spans_checked = 0;
  int unsigned full_closes   = 0;
  int unsigned idle_cycles   = 0;

  column_bounds_to_row_spans #(
    .MAX_ROWS(ROWS)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .column_i        (column),
    .prev_top_i      (prev_top),
    .prev_bottom_i   (prev_bottom),
    .cur_top_i       (cur_top),
    .cur_bottom_i    (cur_bottom),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .span_row_o      (span_row),
    .span_first_col_o(span_first_col),
    .span_last_col_o (span_last_col),
    .last_of_run_o   (last_of_run)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  // A covered row range for one column. Most ranges sit around the store so that rows
  // open and close often; some are empty in either form, and some use the full 16 bits.
  function automatic logic [2*BOUND_W-1:0] random_bounds();
    logic [BOUND_W-1:0] top_row;
    logic [BOUND_W-1:0] bottom_row;
    case ($urandom_range(0, 9))
      0: begin
        top_row    = EMPTY_TOP;
        bottom_row = BOUND_W'($urandom);
      end
      1: begin
        bottom_row = BOUND_W'($urandom_range(0, 60));
        top_row    = bottom_row + BOUND_W'($urandom_range(1, 10));
      end
      2: begin
        top_row    = BOUND_W'($urandom);
        bottom_row = BOUND_W'($urandom);
      end
      default: begin
        top_row    = BOUND_W'($urandom_range(0, 66));
        bottom_row = top_row + BOUND_W'($urandom_range(0, 40));
      end
    endcase
    return {top_row, bottom_row};
  endfunction

  // Works out the spans that one column closes and records the rows that it opens.
  // The walks run in signed integers so that a bound of 65535 plus one does not wrap;
  // rows at or beyond the store are walked over but neither reported nor recorded.
  task automatic predict_spans(input column_item_t item);
    int               old_top;
    int               old_bottom;
    int               new_top;
    int               new_bottom;
    int               limit;
    int               r;
    logic [COL_W-1:0] last_col;
    span_t            closed[$];
    old_top    = int'(item.prev_top);
    old_bottom = int'(item.prev_bottom);
    new_top    = int'(item.cur_top);
    new_bottom = int'(item.cur_bottom);
    // Column zero wraps round to the last column.
    last_col   = item.column - 1'b1;

    // Rows above the new top close first, walking downwards.
    if (old_top < new_top && old_top <= old_bottom) begin
      limit = (new_top - 1 < old_bottom) ? new_top - 1 : old_bottom;
      for (r = old_top; r <= limit && r < int'(ROWS); r++) begin
        closed.push_back('{ROW_W'(r), span_start[r], last_col, 1'b0});
      end
      old_top = limit + 1;
    end
    // Then rows below the new bottom, walking upwards.
    if (old_bottom > new_bottom && old_bottom >= old_top) begin
      limit = (new_bottom + 1 > old_top) ? new_bottom + 1 : old_top;
      for (r = (old_bottom < int'(ROWS) - 1) ? old_bottom : int'(ROWS) - 1; r >= limit; r--) begin
        closed.push_back('{ROW_W'(r), span_start[r], last_col, 1'b0});
      end
      old_bottom = limit - 1;
    end
    // Rows newly covered at the top take this column as their start.
    if (new_top < old_top && new_top <= new_bottom) begin
      limit = (old_top - 1 < new_bottom) ? old_top - 1 : new_bottom;
      for (r = new_top; r <= limit && r < int'(ROWS); r++) begin
        span_start[r] = item.column;
      end
      new_top = limit + 1;
    end
    // Likewise at the bottom.
    if (new_bottom > old_bottom && new_bottom >= new_top) begin
      limit = (old_bottom + 1 > new_top) ? old_bottom + 1 : new_top;
      for (r = (new_bottom < int'(ROWS) - 1) ? new_bottom : int'(ROWS) - 1; r >= limit; r--) begin
        span_start[r] = item.column;
      end
    end

    if (closed.size() != 0) begin
      closed[closed.size() - 1].last_of_run = 1'b1;
    end
    if (closed.size() == int'(ROWS)) begin
      full_closes++;
    end
    foreach (closed[i]) begin
      pending_spans.push_back(closed[i]);
    end
  endtask

  // Offers one column and waits for its transfer. Valid stays high between back-to-back
  // columns; a gap lowers it at one falling edge and raises it at a later one.
  task automatic send_column(input logic [COL_W-1:0] col, input logic [BOUND_W-1:0] p_top,
                             input logic [BOUND_W-1:0] p_bottom,
                             input logic [BOUND_W-1:0] c_top,
                             input logic [BOUND_W-1:0] c_bottom);
    int unsigned  gap;
    column_item_t item;
    item = '{col, p_top, p_bottom, c_top, c_bottom};
    gap  = tx_steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    column      <= col;
    prev_top    <= p_top;
    prev_bottom <= p_bottom;
    cur_top     <= c_top;
    cur_bottom  <= c_bottom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_spans(item);
    columns_sent++;
  endtask

  // Hand-picked columns. The very first one opens every row of the store, so from then on
  // no column can close a row whose start was never recorded, and every later item is legal.
  task automatic test_directed_columns();
    // Whole height opened from an empty column.
    send_column(10'd5, EMPTY_TOP, 16'd0, 16'd0, 16'd63);
    // Both edges shrink: rows close at the top and then at the bottom.
    send_column(10'd6, 16'd0, 16'd63, 16'd10, 16'd50);
    // Both edges grow back: rows open at the top and at the bottom.
    send_column(10'd7, 16'd10, 16'd50, 16'd0, 16'd63);
    // Full height into an empty column: the largest burst of spans.
    send_column(10'd8, 16'd0, 16'd63, EMPTY_TOP, 16'd0);
    send_column(10'd9, EMPTY_TOP, 16'd0, 16'd0, 16'd63);
    // Unchanged coverage closes nothing.
    send_column(10'd0, 16'd0, 16'd63, 16'd0, 16'd63);
    // Column zero: the last column of the span wraps.
    send_column(10'd0, 16'd0, 16'd63, 16'd1, 16'd63);
    // Highest column, closing at the bottom while opening at the top.
    send_column(10'd1023, 16'd1, 16'd63, 16'd0, 16'd62);
    send_column(10'd1, 16'd0, 16'd62, 16'd30, 16'd31);
    // Coverage moves wholly beyond the store.
    send_column(10'd2, 16'd30, 16'd31, 16'd100, 16'd200);
    send_column(10'd3, 16'd100, 16'd200, 16'd20, 16'd40);
    // All-ones bounds on both edges.
    send_column(10'd4, 16'd20, 16'd40, EMPTY_TOP, 16'hFFFF);
    send_column(10'd10, EMPTY_TOP, 16'hFFFF, 16'd0, 16'd0);
    send_column(10'd11, 16'd0, 16'd0, 16'd63, 16'd63);
    send_column(10'd12, 16'd63, 16'd63, 16'd0, 16'd63);
    // An empty range given as a top below its bottom, in both directions.
    send_column(10'd13, 16'd0, 16'd63, 16'd40, 16'd10);
    send_column(10'd14, 16'd40, 16'd10, 16'd0, 16'd63);
    send_column(10'd682, 16'd0, 16'd63, 16'd21, 16'd42);
    send_column(10'd341, 16'd21, 16'd42, 16'd0, 16'd63);
  endtask

  // The receiver holds off for a long stretch while full-height columns keep coming, so
  // the output register fills and the block has to refuse further transfers in.
  task automatic test_output_hold_off();
    logic [COL_W-1:0] col;
    col          = COL_W'($urandom);
    hold_off_req = 1'b1;
    repeat (4) begin
      send_column(col, 16'd0, 16'd63, EMPTY_TOP, 16'd0);
      col++;
      send_column(col, EMPTY_TOP, 16'd0, 16'd0, 16'd63);
      col++;
    end
    wait (!hold_off_req);
  endtask

  // Runs of consecutive columns of one plane: each column's previous bounds are the
  // bounds of the column before it, as a renderer would present them. The first stretch
  // runs with both sides always ready.
  task automatic test_random_planes();
    logic [COL_W-1:0]   col;
    logic [BOUND_W-1:0] top_row;
    logic [BOUND_W-1:0] bottom_row;
    logic [BOUND_W-1:0] next_top;
    logic [BOUND_W-1:0] next_bottom;
    int unsigned        sent;
    sent = 0;
    while (sent < PLANE_ITEMS) begin
      tx_steady  = (sent < STEADY_ITEMS);
      rx_steady  = (sent < STEADY_ITEMS);
      col        = COL_W'($urandom);
      top_row    = EMPTY_TOP;
      bottom_row = BOUND_W'($urandom);
      repeat ($urandom_range(3, 12)) begin
        {next_top, next_bottom} = random_bounds();
        send_column(col, top_row, bottom_row, next_top, next_bottom);
        top_row    = next_top;
        bottom_row = next_bottom;
        col++;
        sent++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Columns whose previous bounds have nothing to do with the column before.
  task automatic test_noise_columns();
    logic [BOUND_W-1:0] p_top;
    logic [BOUND_W-1:0] p_bottom;
    logic [BOUND_W-1:0] c_top;
    logic [BOUND_W-1:0] c_bottom;
    repeat (NOISE_ITEMS) begin
      {p_top, p_bottom} = random_bounds();
      {c_top, c_bottom} = random_bounds();
      send_column(COL_W'($urandom), p_top, p_bottom, c_top, c_bottom);
    end
  endtask

  // Receiver: ready most of the time, with short and long stalls, and one long hold-off
  // when a test asks for it. The hold-off is counted here, in cycles.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
    end
  end

  // Every span transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected span row %0d first %0d last %0d end %0b", $realtime,
                 span_row, span_first_col, span_last_col, last_of_run);
        errors++;
      end else begin
        if (pending_spans[0].span_row !== span_row ||
            pending_spans[0].span_first_col !== span_first_col ||
            pending_spans[0].span_last_col !== span_last_col ||
            pending_spans[0].last_of_run !== last_of_run) begin
          $display("%0t: span mismatch: expected row %0d first %0d last %0d end %0b,", $realtime,
                   pending_spans[0].span_row, pending_spans[0].span_first_col,
                   pending_spans[0].span_last_col, pending_spans[0].last_of_run);
          $display("%0t:   actual row %0d first %0d last %0d end %0b", $realtime, span_row,
                   span_first_col, span_last_col, last_of_run);
          errors++;
        end
        void'(pending_spans.pop_front());
        spans_checked++;
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either side means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d spans outstanding", $realtime,
                 idle_cycles, pending_spans.size());
        $display("column_bounds_to_row_spans test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    column      = '0;
    prev_top    = '0;
    prev_bottom = '0;
    cur_top     = '0;
    cur_bottom  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_columns();
    test_output_hold_off();
    test_random_planes();
    test_noise_columns();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_spans.size() == 0);
    // Give a stray extra span time to show itself.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_spans.size() != 0) begin
      $display("%0t: %0d predicted spans never arrived", $realtime, pending_spans.size());
      errors++;
    end

    $display("Covered %0d columns and %0d spans, %0d of them full-height closes,",
             columns_sent, spans_checked, full_closes);
    $display("with wrapped and extreme columns, empty ranges and a long output hold-off.");
    if (errors == 0) begin
      $display("column_bounds_to_row_spans test passed");
    end else begin
      $display("column_bounds_to_row_spans test failed");
    end
    $finish;
  end

endmodule
